// File: hw/rtl/rkdg_pkg.sv
package rkdg_pkg;

    // Pipeline depths
    localparam int LANE_LAT = 14;
    localparam int ADV_LAT  = 7;
    localparam int PIPE_LAT = LANE_LAT + ADV_LAT;

    // Lane and result counts
    localparam int N_LANE = 6;
    localparam int N_OUT  = 9;

    // Field widths
    localparam int GRAV_W = 23;
    localparam int DRAG_W = 17;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_GRAVITY = 1'b0,
        CFG_DRAG    = 1'b1
    } t_cfg_idx;

    localparam logic [GRAV_W-1:0] GRAVITY_RST = 23'd655360;
    localparam logic [DRAG_W-1:0] DRAG_RST    = 17'd6554;

    // Saturation bounds on the wide intermediate form
    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

    // Round-to-nearest offset for a Q16.16 product
    localparam logic signed [49:0] RND_HALF = 50'sd32768;

    // Final update: bias keeps the scaled sum non-negative ahead of the divide by 3.
    // Bias = 3*2^50 (becomes 3*2^33 after the shift) plus the rounding term 3*2^16.
    localparam logic signed [53:0] ADV_BIAS = 54'sd3377699720724480;
    localparam logic signed [35:0] DLT_OFS  = 36'sd8589934592;
    // 2^20 = 3*349525 + 1, so u/3 splits into a high product and a small remainder part
    localparam logic [18:0] DIV3_HI  = 19'd349525;
    // (2^23 + 1) / 3: exact reciprocal for values below 2^22
    localparam logic [21:0] DIV3_MUL = 22'd2796203;

    // Per-stage payload of one lane
    typedef struct packed {
        logic signed [31:0] y;
        logic [16:0]        dt;
        logic [3:0][31:0]   s;
        logic [3:0][31:0]   k;
        logic signed [49:0] p;
    } t_lane_st;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Signed Q16.16 value times an unsigned 17-bit Q1.16 value, exact
    function automatic logic signed [49:0] mul_q(input logic signed [31:0] a,
                                                input logic [16:0] m);
        logic signed [49:0] ae;
        logic signed [49:0] me;
        ae = {{18{a[31]}}, a};
        me = {33'b0, m};
        return ae * me;
    endfunction

    // Round an exact product back to Q16.16, ties up, then saturate
    function automatic logic signed [31:0] qround(input logic signed [49:0] p);
        logic signed [49:0] t;
        t = p + RND_HALF;
        return sat32({{2{t[49]}}, t[49:16]});
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return sat32({{4{a[31]}}, a} + {{4{b[31]}}, b});
    endfunction

    // Derivative: minus rounded drag product minus gravity term
    function automatic logic signed [31:0] slope(input logic signed [49:0] p,
                                                input logic [22:0] g);
        logic signed [31:0] q;
        q = qround(p);
        return sat32(-$signed({{4{q[31]}}, q}) - $signed({13'b0, g}));
    endfunction

endpackage

// File: hw/rtl/rkdg_lane.sv
module rkdg_lane (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_y,
    input  logic [16:0]         i_dt,
    input  logic [22:0]         i_grav,
    input  logic [16:0]         i_drag,
    output logic signed [31:0]  o_y,
    output logic [16:0]         o_dt,
    output logic [3:0][31:0]    o_s,
    output logic [3:0][31:0]    o_k
);

    rkdg_pkg::t_lane_st w_in;
    rkdg_pkg::t_lane_st r_st [rkdg_pkg::LANE_LAT];

    // Load the lane's entry payload
    always_comb begin
        w_in    = '0;
        w_in.y  = i_y;
        w_in.dt = i_dt;
    end

    // Four phases per RK stage: k*h product, trial state, drag product, slope.
    // The first stage starts at the drag product since its trial state is y itself.
    for (genvar gi = 0; gi < rkdg_pkg::LANE_LAT; gi++) begin : g_stg
        localparam int PH = (gi + 2) % 4;
        localparam int RK = (gi + 2) / 4;
        localparam int KP = (RK > 0) ? RK - 1 : 0;

        rkdg_pkg::t_lane_st w_prev;
        rkdg_pkg::t_lane_st w_next;

        if (gi == 0) begin : g_first
            assign w_prev = w_in;
        end else begin : g_rest
            assign w_prev = r_st[gi-1];
        end

        always_comb begin
            w_next = w_prev;
            case (PH)
                0: begin
                    // last stage steps a full dt, the middle ones half of it
                    w_next.p = rkdg_pkg::mul_q($signed(w_prev.k[KP]),
                        (RK == 3) ? w_prev.dt : {1'b0, w_prev.dt[16:1]});
                end
                1: begin
                    w_next.s[RK] = rkdg_pkg::add_sat(w_prev.y, rkdg_pkg::qround(w_prev.p));
                end
                2: begin
                    if (RK == 0) begin
                        w_next.s[0] = w_prev.y;
                    end
                    w_next.p = rkdg_pkg::mul_q(
                        (RK == 0) ? w_prev.y : $signed(w_prev.s[RK]), i_drag);
                end
                3: begin
                    w_next.k[RK] = rkdg_pkg::slope(w_prev.p, i_grav);
                end
                default: begin
                    w_next = w_prev;
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[gi] <= w_next;
            end
        end
    end

    assign o_y  = r_st[rkdg_pkg::LANE_LAT-1].y;
    assign o_dt = r_st[rkdg_pkg::LANE_LAT-1].dt;
    assign o_s  = r_st[rkdg_pkg::LANE_LAT-1].s;
    assign o_k  = r_st[rkdg_pkg::LANE_LAT-1].k;

endmodule

// File: hw/rtl/rkdg_advance.sv
module rkdg_advance (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_base,
    input  logic [3:0][31:0]    i_k,
    input  logic [16:0]         i_dt,
    output logic signed [31:0]  o_new
);

    logic signed [32:0] w_t14;
    logic signed [32:0] w_t23;
    logic signed [34:0] w_sum;
    logic signed [51:0] w_prod;
    logic signed [53:0] w_bias;
    logic [34:0]        w_hi;
    logic [20:0]        w_c;
    logic [42:0]        w_p2;
    logic signed [35:0] w_dlt;

    logic signed [32:0] r1_t14;
    logic signed [32:0] r1_t23;
    logic signed [31:0] r1_base;
    logic [16:0]        r1_dt;
    logic signed [34:0] r2_sum;
    logic signed [31:0] r2_base;
    logic [16:0]        r2_dt;
    logic signed [51:0] r3_prod;
    logic signed [31:0] r3_base;
    logic [35:0]        r4_u;
    logic signed [31:0] r4_base;
    logic [34:0]        r5_hi;
    logic [20:0]        r5_c;
    logic signed [31:0] r5_base;
    logic [34:0]        r6_hi;
    logic [19:0]        r6_q;
    logic signed [31:0] r6_base;
    logic signed [35:0] r7_dlt;
    logic signed [31:0] r7_base;

    always_comb begin
        // pair the slopes, then weight as k1 + 2(k2 + k3) + k4
        w_t14  = $signed({i_k[0][31], i_k[0]}) + $signed({i_k[3][31], i_k[3]});
        w_t23  = $signed({i_k[1][31], i_k[1]}) + $signed({i_k[2][31], i_k[2]});
        w_sum  = $signed({{2{r1_t14[32]}}, r1_t14}) + $signed({r1_t23[32], r1_t23, 1'b0});
        w_prod = $signed({{17{r2_sum[34]}}, r2_sum}) * $signed({35'b0, r2_dt});
        // biased scaled sum, divided by 2^17; non-negative below 2^36
        w_bias = $signed({{2{r3_prod[51]}}, r3_prod}) + rkdg_pkg::ADV_BIAS;
        // divide by 3 in two parts: high digit times (2^20-1)/3, remainder via reciprocal
        w_hi   = {19'b0, r4_u[35:20]} * {16'b0, rkdg_pkg::DIV3_HI};
        w_c    = {5'b0, r4_u[35:20]} + {1'b0, r4_u[19:0]};
        w_p2   = {22'b0, r5_c} * {21'b0, rkdg_pkg::DIV3_MUL};
        // drop the bias again
        w_dlt  = $signed({1'b0, r6_hi}) + $signed({16'b0, r6_q}) - rkdg_pkg::DLT_OFS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t14  <= w_t14;
            r1_t23  <= w_t23;
            r1_base <= i_base;
            r1_dt   <= i_dt;
            r2_sum  <= w_sum;
            r2_base <= r1_base;
            r2_dt   <= r1_dt;
            r3_prod <= w_prod;
            r3_base <= r2_base;
            r4_u    <= w_bias[52:17];
            r4_base <= r3_base;
            r5_hi   <= w_hi;
            r5_c    <= w_c;
            r5_base <= r4_base;
            r6_hi   <= r5_hi;
            r6_q    <= w_p2[42:23];
            r6_base <= r5_base;
            r7_dlt  <= w_dlt;
            r7_base <= r6_base;
        end
    end

    assign o_new = rkdg_pkg::sat32({{4{r7_base[31]}}, r7_base} + r7_dlt);

endmodule

// File: hw/rtl/rk4_drag_gravity_integrator.sv
// One classical RK4 step for a body under gravity (down on y) and linear drag on
// both velocity and angular velocity, signed Q16.16 with saturation throughout.
// Six slope lanes (three velocity axes, three spin axes) run the four RK stages
// in parallel, and nine update units merge the slopes into the new position,
// velocity and spin. Position slopes are the velocity lanes' trial states. The
// block takes one body per clock while the skid is empty; each result passes
// through the 14-stage slope lanes (two stages per multiply and its rounding,
// four per RK stage), then the 7-stage weighted update and its divide by six.
// A one-entry skid behind the output register keeps input flowing while a
// result waits; input stalls only once both are full. Configuration writes
// take effect at once and should be made with no body in flight.
module rk4_drag_gravity_integrator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration: index 0 gravity_accel, index 1 drag_coeff
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_idx,
    input  logic [22:0]    i_cfg_data,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, spin_x, spin_y, spin_z (32 each),
    // step_time (17), zero pad (7)
    input  logic [311:0]   s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    // new_spin_x, new_spin_y, new_spin_z (32 each)
    output logic [287:0]   m_axis_tdata
);

    localparam int LAT = rkdg_pkg::PIPE_LAT;
    localparam int LL  = rkdg_pkg::LANE_LAT;

    logic [22:0]            r_gravity;
    logic [16:0]            r_drag;
    logic [LAT-1:0]         r_vld;
    logic [2:0][31:0]       r_pos_dly [LL];
    logic                   r_out_vld;
    logic                   r_skd_vld;
    logic [287:0]           r_out_data;
    logic [287:0]           r_skd_data;
    logic                   n_out_vld;
    logic                   n_skd_vld;
    logic                   w_pipe_en;
    logic                   w_in_fire;
    logic                   w_out_take;
    logic                   w_load_out;
    logic                   w_load_skd;
    logic                   w_pipe_vld;
    logic [287:0]           w_pipe_data;
    logic [16:0]            w_dt;

    logic signed [31:0]     w_ly  [rkdg_pkg::N_LANE];
    logic [16:0]            w_ldt [rkdg_pkg::N_LANE];
    logic [3:0][31:0]       w_ls  [rkdg_pkg::N_LANE];
    logic [3:0][31:0]       w_lk  [rkdg_pkg::N_LANE];

    assign w_dt       = s_axis_tdata[304:288];
    assign w_pipe_en  = !r_skd_vld;
    assign w_in_fire  = s_axis_tvalid && w_pipe_en;
    assign w_out_take = r_out_vld && m_axis_tready;
    assign w_pipe_vld = r_vld[LAT-1];

    assign s_axis_tready = w_pipe_en;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= rkdg_pkg::GRAVITY_RST;
            r_drag    <= rkdg_pkg::DRAG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rkdg_pkg::CFG_GRAVITY: r_gravity <= i_cfg_data;
                rkdg_pkg::CFG_DRAG:    r_drag    <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Advance the valid line with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_pipe_en) begin
            r_vld <= {r_vld[LAT-2:0], w_in_fire};
        end
    end

    // Hold positions until the velocity lanes deliver their slopes
    always_ff @(posedge i_clk) begin
        if (w_pipe_en) begin
            r_pos_dly[0] <= s_axis_tdata[95:0];
            for (int i = 1; i < LL; i++) begin
                r_pos_dly[i] <= r_pos_dly[i-1];
            end
        end
    end

    // Slope lanes: 0..2 velocity, 3..5 spin; gravity acts on velocity y only
    for (genvar li = 0; li < rkdg_pkg::N_LANE; li++) begin : g_lane
        rkdg_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_pipe_en),
            .i_y    (s_axis_tdata[(3+li)*32 +: 32]),
            .i_dt   (w_dt),
            .i_grav ((li == 1) ? r_gravity : 23'd0),
            .i_drag (r_drag),
            .o_y    (w_ly[li]),
            .o_dt   (w_ldt[li]),
            .o_s    (w_ls[li]),
            .o_k    (w_lk[li])
        );
    end

    // Merge slopes into the nine updated components
    for (genvar oi = 0; oi < rkdg_pkg::N_OUT; oi++) begin : g_adv
        if (oi < 3) begin : g_pos
            rkdg_advance u_adv (
                .i_clk  (i_clk),
                .i_en   (w_pipe_en),
                .i_base ($signed(r_pos_dly[LL-1][oi])),
                .i_k    (w_ls[oi]),
                .i_dt   (w_ldt[oi]),
                .o_new  (w_pipe_data[oi*32 +: 32])
            );
        end else begin : g_rate
            rkdg_advance u_adv (
                .i_clk  (i_clk),
                .i_en   (w_pipe_en),
                .i_base (w_ly[oi-3]),
                .i_k    (w_lk[oi-3]),
                .i_dt   (w_ldt[oi-3]),
                .o_new  (w_pipe_data[oi*32 +: 32])
            );
        end
    end

    // Output register and skid: fill the output when free, else park in the skid
    always_comb begin
        n_out_vld  = r_out_vld;
        n_skd_vld  = r_skd_vld;
        w_load_out = 1'b0;
        w_load_skd = 1'b0;
        if (r_skd_vld) begin
            if (w_out_take) begin
                w_load_out = 1'b1;
                n_skd_vld  = 1'b0;
            end
        end else if (w_pipe_vld) begin
            if (!r_out_vld || m_axis_tready) begin
                w_load_out = 1'b1;
                n_out_vld  = 1'b1;
            end else begin
                w_load_skd = 1'b1;
                n_skd_vld  = 1'b1;
            end
        end else if (w_out_take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_skd_vld <= n_skd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= r_skd_vld ? r_skd_data : w_pipe_data;
        end
        if (w_load_skd) begin
            r_skd_data <= w_pipe_data;
        end
    end

    // A parked result implies the output register is occupied
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid holds a result while the output register is empty");

    // No new transaction enters while the skid is full
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> !s_axis_tready)
        else $error("input accepted while the skid is full");

    // The pipeline freezes while a result is parked
    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

endmodule
